// ===== src/dre_pkg.sv =====
// Shared types and constants for the delimited record extractor.
// Used by the front, queue, back and top-level modules; no dependencies.
package dre_pkg;

    // Character classes for the byte filter.
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TILDE = 8'h7E;

    // Reset values of the configuration registers.
    localparam logic [7:0]  DELIM_RESET    = 8'd10;
    localparam logic [15:0] CAPACITY_RESET = 16'd64;
    localparam logic [15:0] SCAN_RESET     = 16'd100;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // Configuration register index, taken from paddr[3:2].
    typedef enum logic [1:0] {
        REG_DELIMITER  = 2'd0,
        REG_CAPACITY   = 2'd1,
        REG_SCAN_LIMIT = 2'd2,
        REG_UNUSED     = 2'd3
    } reg_index_t;

    // Record status codes.
    typedef enum logic [2:0] {
        ST_RUN       = 3'd0,
        ST_OK        = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_TIMEOUT   = 3'd3,
        ST_NEED_MORE = 3'd4,
        ST_PARTIAL   = 3'd5
    } status_t;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic [7:0]  delimiter;
        logic [15:0] record_capacity;
        logic [15:0] scan_limit;
    } cfg_t;

    // One classified input item.
    typedef struct packed {
        logic       mode;
        logic [7:0] byte_value;
        logic       is_delim;
        logic       is_kept;
    } item_t;

    // One result item.
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_kept;
        logic        consumed;
        status_t     status;
        logic [15:0] record_len;
        logic        record_end;
    } result_t;

endpackage

// ===== src/dre_front.sv =====
// Front end of the record extractor: accepts input transfers and classifies each byte.
// Depends on dre_pkg; feeds dre_queue.
module dre_front
    import dre_pkg::*;
(
    input  logic       in_valid,
    input  logic       mode,
    input  logic [7:0] byte_value,
    input  logic [7:0] delimiter,
    input  logic       queue_full,
    output logic       in_stall,
    output logic       push,
    output item_t      item
);

    logic is_printable;

    // Hold off the source while the queue has no free entry.
    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

    // Classify the byte against the delimiter and the keep filter.
    assign is_printable = (byte_value >= CHAR_SPACE) && (byte_value <= CHAR_TILDE);

    always_comb
    begin
        item.mode       = mode;
        item.byte_value = byte_value;
        item.is_delim   = (byte_value == delimiter);
        item.is_kept    = is_printable || (byte_value == CHAR_TAB) || (byte_value == CHAR_CR);
    end

endmodule

// ===== src/dre_queue.sv =====
// Short FIFO of classified items between the front and the back.
// Depends on dre_pkg.
module dre_queue
    import dre_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    input  logic  pop,
    output item_t pop_item,
    output logic  full,
    output logic  empty
);

    item_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = entry_reg[rd_ptr_reg];

    // Pointer and fill-count update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== src/dre_back.sv =====
// Back end of the record extractor: record counters, status decision and output register.
// Depends on dre_pkg; drains dre_queue.
module dre_back
    import dre_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  item_t   item,
    input  logic    queue_empty,
    output logic    pop,
    input  logic    out_stall,
    output logic    out_valid,
    output result_t result
);

    localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    logic [COUNT_WIDTH-1:0] kept_reg;
    logic [COUNT_WIDTH-1:0] kept_next;
    logic [COUNT_WIDTH-1:0] scanned_reg;
    logic [COUNT_WIDTH-1:0] scanned_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    result_t                result_reg;
    result_t                result_next;
    logic [CMP_W-1:0]       kept_ext;
    logic [CMP_W-1:0]       scanned_ext;
    logic                   scan_hit;
    logic                   cap_hit;

    // Take an item when the output register is free or being drained.
    assign pop = !queue_empty && (!out_valid_reg || !out_stall);

    assign kept_ext    = CMP_W'(kept_reg);
    assign scanned_ext = CMP_W'(scanned_reg);
    assign scan_hit    = scanned_ext >= CMP_W'(cfg.scan_limit);
    assign cap_hit     = kept_ext >= CMP_W'(cfg.record_capacity);

    // Record decision: end of input, scan limit, delimiter, capacity, then filter.
    always_comb
    begin
        kept_next              = kept_reg;
        scanned_next           = scanned_reg;
        result_next.out_byte   = 8'd0;
        result_next.byte_kept  = 1'b0;
        result_next.consumed   = 1'b0;
        result_next.status     = ST_RUN;
        result_next.record_len = 16'd0;
        result_next.record_end = 1'b0;
        priority if (item.mode)
        begin
            result_next.status     = (kept_reg == '0) ? ST_NEED_MORE : ST_PARTIAL;
            result_next.record_len = kept_ext[15:0];
            result_next.record_end = 1'b1;
            kept_next              = '0;
            scanned_next           = '0;
        end
        else if (scan_hit)
        begin
            result_next.status     = ST_TIMEOUT;
            result_next.record_len = kept_ext[15:0];
            result_next.record_end = 1'b1;
            kept_next              = '0;
            scanned_next           = '0;
        end
        else if (item.is_delim)
        begin
            result_next.status     = ST_OK;
            result_next.consumed   = 1'b1;
            result_next.record_len = kept_ext[15:0];
            result_next.record_end = 1'b1;
            kept_next              = '0;
            scanned_next           = '0;
        end
        else if (cap_hit)
        begin
            result_next.status     = ST_OVERFLOW;
            result_next.record_len = kept_ext[15:0];
            result_next.record_end = 1'b1;
            kept_next              = '0;
            scanned_next           = '0;
        end
        else
        begin
            result_next.consumed = 1'b1;
            scanned_next = (scanned_reg == COUNT_MAX) ? COUNT_MAX : scanned_reg + 1'b1;
            if (item.is_kept)
            begin
                result_next.out_byte  = item.byte_value;
                result_next.byte_kept = 1'b1;
                kept_next = (kept_reg == COUNT_MAX) ? COUNT_MAX : kept_reg + 1'b1;
            end
        end
    end

    assign out_valid_next = pop || (out_valid_reg && out_stall);

    // Counters and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kept_reg      <= '0;
            scanned_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                kept_reg    <= kept_next;
                scanned_reg <= scanned_next;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    // A record end always leaves both counters cleared.
    a_clear_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        pop && result_next.record_end |=> (kept_reg == '0) && (scanned_reg == '0))
        else $error("counters not cleared after record end");

    // Every kept byte was also scanned.
    a_kept_le_scanned: assert property (@(posedge clk) disable iff (!rst_n)
        kept_reg <= scanned_reg)
        else $error("kept count exceeds scanned count");

    // A kept byte never closes a record.
    a_kept_in_progress: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.byte_kept |->
            !result_reg.record_end && (result_reg.status == ST_RUN) && result_reg.consumed)
        else $error("kept byte with a closing status");

    // Timeout and overflow results hand the byte back.
    a_not_consumed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && ((result_reg.status == ST_TIMEOUT) ||
                          (result_reg.status == ST_OVERFLOW)) |-> !result_reg.consumed)
        else $error("timeout or overflow marked as consumed");

endmodule

// ===== src/delimited_record_extractor_core.sv =====
// Delimited record extractor: an input transfer is held in a queue entry and then in the
// output register. Throughput is one byte per cycle while out_stall is low.
// A two-entry queue decouples the input front end from the counter and output stage.
// Reset (rst_n low, asynchronous) clears counters, queue and output valid, and loads
// delimiter 10, record capacity 64 and scan limit 100. No clearing pass is needed.
module delimited_record_extractor_core
    import dre_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [7:0]  byte_value,
    // Output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        byte_kept,
    output logic        consumed,
    output logic [2:0]  status,
    output logic [15:0] record_len,
    output logic        record_end
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    reg_index_t reg_index;
    logic       cfg_write;
    logic       push;
    item_t      push_item;
    item_t      pop_item;
    logic       queue_full;
    logic       queue_empty;
    logic       pop;
    result_t    result;

    // Configuration register writes and reads.
    assign pready    = 1'b1;
    assign reg_index = reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (reg_index)
                REG_DELIMITER:  cfg_next.delimiter       = pwdata[7:0];
                REG_CAPACITY:   cfg_next.record_capacity = pwdata[15:0];
                REG_SCAN_LIMIT: cfg_next.scan_limit      = pwdata[15:0];
                REG_UNUSED:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_DELIMITER:  prdata = {24'd0, cfg_reg.delimiter};
            REG_CAPACITY:   prdata = {16'd0, cfg_reg.record_capacity};
            REG_SCAN_LIMIT: prdata = {16'd0, cfg_reg.scan_limit};
            REG_UNUSED:     prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.delimiter       <= DELIM_RESET;
            cfg_reg.record_capacity <= CAPACITY_RESET;
            cfg_reg.scan_limit      <= SCAN_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: input transfers and byte classification.
    dre_front u_front (
        .in_valid   (in_valid),
        .mode       (mode),
        .byte_value (byte_value),
        .delimiter  (cfg_reg.delimiter),
        .queue_full (queue_full),
        .in_stall   (in_stall),
        .push       (push),
        .item       (push_item)
    );

    // Queue between the two halves.
    dre_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    // Back end: counters, status and output register.
    dre_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .item        (pop_item),
        .queue_empty (queue_empty),
        .pop         (pop),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .result      (result)
    );

    assign out_byte   = result.out_byte;
    assign byte_kept  = result.byte_kept;
    assign consumed   = result.consumed;
    assign status     = result.status;
    assign record_len = result.record_len;
    assign record_end = result.record_end;

endmodule
